>>> sv/pcpa_pkg.sv
package pcpa_pkg;

  localparam int CPUS_DEF       = 8;
  localparam int MAX_PAGES_DEF  = 32768;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int CPU_W          = 3;
  localparam int ADDR_W         = 32;
  localparam int Q_DEPTH        = 2;

  localparam logic [ADDR_W-1:0] POOL_BASE_RST  = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] POOL_LIMIT_RST = 32'h8800_0000;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADADDR = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_POOL_BASE  = 1'b0,
    REG_POOL_LIMIT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic              opcode;
    logic [CPU_W-1:0]  cpu;
    logic [ADDR_W-1:0] page_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_addr;
  } rsp_t;

  typedef struct packed {
    logic                  index;
    logic [ADDR_W-1:0]     data;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    BE_IDLE,
    BE_POP_RD,
    BE_POP_WAIT,
    BE_SCAN,
    BE_WALK_RD,
    BE_WALK_WAIT,
    BE_TAKE_RD,
    BE_TAKE_WAIT,
    BE_DONE
  } be_state_t;

endpackage

>>> sv/pcpa_ram.sv
module pcpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pcpa_front.sv
module pcpa_front #(
  parameter int CPUS       = pcpa_pkg::CPUS_DEF,
  parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  pcpa_pkg::req_t                         in_item,
  input  logic [pcpa_pkg::ADDR_W-1:0]            pool_base,
  input  logic [pcpa_pkg::ADDR_W-1:0]            pool_limit,
  output logic                                   q_valid,
  input  logic                                   q_ready,
  output logic                                   q_free,
  output logic                                   q_bad,
  output logic [$clog2(CPUS > 1 ? CPUS : 2)-1:0] q_cpu,
  output logic [$clog2(MAX_PAGES)-1:0]           q_idx
);
  import pcpa_pkg::*;

  localparam int CW = $clog2(CPUS > 1 ? CPUS : 2);
  localparam int IW = $clog2(MAX_PAGES);
  localparam int PB = $clog2(PAGE_BYTES);
  localparam int QW = 2 + CW + IW;

  // Classify: reduce cpu, check address, compute page index
  logic [ADDR_W-1:0] base_al, offs;
  logic [ADDR_W-PB-1:0] pidx;
  logic [CW-1:0]     cpu_m;
  logic              bad;
  logic [QW-1:0]     ent;

  always_comb begin
    base_al = {pool_base[ADDR_W-1:PB], {PB{1'b0}}};
    offs    = in_item.page_addr - base_al;
    pidx    = offs[ADDR_W-1:PB];
    // cpu reduced through a small constant table
    cpu_m   = '0;
    for (int i = 0; i < 2**CPU_W; i++) begin
      if (in_item.cpu == CPU_W'(i)) cpu_m = CW'(i % CPUS);
    end
    bad     = (in_item.page_addr[PB-1:0] != '0) || (in_item.page_addr < pool_base)
           || (in_item.page_addr >= pool_limit)
           || ((ADDR_W-PB) > IW && (pidx >> IW) != '0);
    ent     = {in_item.opcode == OP_FREE, bad, cpu_m, IW'(pidx)};
  end

  // Two-entry queue towards the back end
  logic [QW-1:0] qmem [Q_DEPTH];
  logic          wp, rp;
  logic [1:0]    cnt;
  logic          push, pop;

  assign in_ready = (cnt != 2'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign pop      = q_valid && q_ready;
  assign {q_free, q_bad, q_cpu, q_idx} = qmem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wp] <= ent;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> sv/pcpa_back.sv
module pcpa_back #(
  parameter int CPUS       = pcpa_pkg::CPUS_DEF,
  parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   q_valid,
  output logic                                   q_ready,
  input  logic                                   q_free,
  input  logic                                   q_bad,
  input  logic [$clog2(CPUS > 1 ? CPUS : 2)-1:0] q_cpu,
  input  logic [$clog2(MAX_PAGES)-1:0]           q_idx,
  input  logic [pcpa_pkg::ADDR_W-1:0]            pool_base,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output pcpa_pkg::rsp_t                         out_item
);
  import pcpa_pkg::*;

  localparam int CW = $clog2(CPUS > 1 ? CPUS : 2);
  localparam int IW = $clog2(MAX_PAGES);
  localparam int NW = $clog2(MAX_PAGES + 1);
  localparam int PB = $clog2(PAGE_BYTES);

  // Per-CPU heads and counts
  logic [IW-1:0] head  [CPUS];
  logic [NW-1:0] count [CPUS];

  logic          we;
  logic [IW-1:0] waddr, wdata, raddr, rdata;

  pcpa_ram #(.WIDTH(IW), .DEPTH(MAX_PAGES)) u_link (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  be_state_t     state, state_next;
  logic [CW-1:0] cur, cur_next, vic, vic_next;
  logic [CW:0]   step, step_next;
  logic [NW-1:0] walk, walk_next;
  logic [IW-1:0] page, page_next;
  rsp_t          res, res_next;
  logic          ovalid, ovalid_next;

  logic          hd_we, cn_we;
  logic [CW-1:0] hd_sel, cn_sel;
  logic [IW-1:0] hd_val;
  logic [NW-1:0] cn_val;
  logic          hd2_we, cn2_we;
  logic [IW-1:0] hd2_val;
  logic [NW-1:0] cn2_val;
  logic [CW+1:0] vic_sum;
  logic [CW-1:0] vic_try;

  assign out_valid = ovalid;
  assign out_item  = res;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] b,
                                                input logic [IW-1:0] i);
    logic [ADDR_W-1:0] ba;
    ba = {b[ADDR_W-1:PB], {PB{1'b0}}};
    return ba + (ADDR_W'(i) << PB);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BE_IDLE;
      ovalid <= 1'b0;
      for (int i = 0; i < CPUS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
      if (hd_we)  head[hd_sel]  <= hd_val;
      if (cn_we)  count[cn_sel] <= cn_val;
      if (hd2_we) head[cur]     <= hd2_val;
      if (cn2_we) count[cur]    <= cn2_val;
    end
    cur  <= cur_next;
    vic  <= vic_next;
    step <= step_next;
    walk <= walk_next;
    page <= page_next;
    res  <= res_next;
  end

  // Sequencer: push, pop, or scan and walk a victim list
  always_comb begin
    state_next  = state;
    ovalid_next = ovalid && !out_ready;
    cur_next = cur; vic_next = vic; step_next = step;
    walk_next = walk; page_next = page; res_next = res;
    q_ready = 1'b0;
    we = 1'b0; waddr = q_idx; wdata = head[q_cpu]; raddr = page;
    hd_we = 1'b0; cn_we = 1'b0; hd_sel = cur; cn_sel = cur;
    hd_val = '0; cn_val = '0;
    hd2_we = 1'b0; cn2_we = 1'b0; hd2_val = '0; cn2_val = '0;
    // cur + step stays below 2*CPUS, so one subtract wraps it
    vic_sum = (CW+2)'(cur) + (CW+2)'(step);
    vic_try = (32'(vic_sum) >= CPUS) ? CW'(vic_sum - (CW+2)'(CPUS)) : CW'(vic_sum);
    case (state)
      BE_IDLE: begin
        if (q_valid && !ovalid) begin
          q_ready  = 1'b1;
          cur_next = q_cpu;
          if (q_free) begin
            res_next.alloc_addr = '0;
            if (q_bad || count[q_cpu] == NW'(MAX_PAGES)) begin
              res_next.status = ST_BADADDR;
            end else begin
              res_next.status = ST_OK;
              we = 1'b1;
              hd_we = 1'b1; hd_sel = q_cpu; hd_val = q_idx;
              cn_we = 1'b1; cn_sel = q_cpu; cn_val = count[q_cpu] + 1'b1;
            end
            state_next = BE_DONE;
          end else if (count[q_cpu] != '0) begin
            page_next  = head[q_cpu];
            state_next = BE_POP_RD;
          end else begin
            step_next  = (CW+1)'(1);
            state_next = BE_SCAN;
          end
        end
      end
      BE_POP_RD: begin
        raddr = page;
        state_next = BE_POP_WAIT;
      end
      BE_POP_WAIT: begin
        hd_we = 1'b1; hd_val = rdata;
        cn_we = 1'b1; cn_val = count[cur] - 1'b1;
        res_next.status = ST_OK;
        res_next.alloc_addr = addr_of(pool_base, page);
        state_next = BE_DONE;
      end
      // One candidate victim per cycle, round robin from cpu+1
      BE_SCAN: begin
        if (32'(step) >= CPUS) begin
          res_next.status = ST_OOM;
          res_next.alloc_addr = '0;
          state_next = BE_DONE;
        end else if (count[vic_try] > NW'(1)) begin
          vic_next  = vic_try;
          page_next = head[vic_try];
          walk_next = count[vic_try] >> 1;
          cn_we = 1'b1; cn_sel = vic_try; cn_val = count[vic_try] >> 1;
          hd2_we = 1'b0;
          cn2_we = 1'b1;
          cn2_val = count[vic_try] - (count[vic_try] >> 1) - 1'b1;
          state_next = BE_WALK_RD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      BE_WALK_RD: begin
        raddr = page;
        state_next = BE_WALK_WAIT;
      end
      BE_WALK_WAIT: begin
        page_next = rdata;
        walk_next = walk - 1'b1;
        state_next = (walk == NW'(1)) ? BE_TAKE_RD : BE_WALK_RD;
      end
      BE_TAKE_RD: begin
        raddr = page;
        state_next = BE_TAKE_WAIT;
      end
      BE_TAKE_WAIT: begin
        hd2_we = 1'b1; hd2_val = rdata;
        res_next.status = ST_OK;
        res_next.alloc_addr = addr_of(pool_base, page);
        state_next = BE_DONE;
      end
      BE_DONE: begin
        ovalid_next = 1'b1;
        state_next  = BE_IDLE;
      end
      default: state_next = BE_IDLE;
    endcase
  end

endmodule

>>> sv/per_cpu_page_allocator_steal.sv
// Per-CPU page allocator with stealing.
// Channels: in (opcode, cpu, page_addr) and out (status, alloc_addr), both
// valid/ready; one result item for every request item, in order. A config
// channel writes pool_base (index 0) and pool_limit (index 1); write it only
// while the block is idle.
// A front end checks the free address and computes the page index, then
// queues the item (two entries). The back end owns the link RAM (one write
// and one registered read port) and the per-CPU heads and counts.
// A free writes the link, head and count directly; a local pop reads the
// link RAM for the next head. An allocate from an empty list scans one CPU
// per cycle and then walks count/2 links of the victim list, one link RAM
// read each, before it takes the next page.
// Reset empties every list and restores the pool registers; links are
// written only by frees. A stalled receiver holds the result register; the
// back end then waits, and the front end keeps accepting until its queue is
// full.
module per_cpu_page_allocator_steal #(
  parameter int CPUS       = pcpa_pkg::CPUS_DEF,
  parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pcpa_pkg::req_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output pcpa_pkg::rsp_t out_item,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  pcpa_pkg::cfg_t cfg_item
);
  import pcpa_pkg::*;

  localparam int CW = $clog2(CPUS > 1 ? CPUS : 2);
  localparam int IW = $clog2(MAX_PAGES);

  logic [ADDR_W-1:0] pool_base, pool_limit;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= POOL_BASE_RST;
      pool_limit <= POOL_LIMIT_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_item.index))
        REG_POOL_BASE:  pool_base  <= cfg_item.data;
        REG_POOL_LIMIT: pool_limit <= cfg_item.data;
        default: ;
      endcase
    end
  end

  logic          q_valid, q_ready, q_free, q_bad;
  logic [CW-1:0] q_cpu;
  logic [IW-1:0] q_idx;

  pcpa_front #(.CPUS(CPUS), .MAX_PAGES(MAX_PAGES), .PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item, .pool_base, .pool_limit,
    .q_valid, .q_ready, .q_free, .q_bad, .q_cpu, .q_idx
  );

  pcpa_back #(.CPUS(CPUS), .MAX_PAGES(MAX_PAGES), .PAGE_BYTES(PAGE_BYTES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_free, .q_bad, .q_cpu, .q_idx, .pool_base,
    .out_valid, .out_ready, .out_item
  );

endmodule
